@@ hw/rtl/sadsr_pkg.sv @@
package sadsr_pkg;

    localparam int LENGTH_BITS = 24;
    localparam int LEVEL_BITS  = 16;
    localparam int SHAPE_BITS  = 12;
    localparam int PHASE_BITS  = 17;
    localparam int MUL_BITS    = 32;

    localparam logic [LEVEL_BITS-1:0] FULL_LEVEL = 16'h8000;
    localparam logic [PHASE_BITS-1:0] ONE_Q16    = 17'h10000;

    // Stage codes
    localparam logic [2:0] ST_OFF     = 3'd0;
    localparam logic [2:0] ST_ATTACK  = 3'd1;
    localparam logic [2:0] ST_DECAY   = 3'd2;
    localparam logic [2:0] ST_SUSTAIN = 3'd3;
    localparam logic [2:0] ST_RELEASE = 3'd4;
    localparam logic [2:0] ST_END     = 3'd5;

    // Opcodes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_ENTER = 1'b1;

    // Register indexes
    localparam logic [2:0] CFG_ATTACK_LEN  = 3'd0;
    localparam logic [2:0] CFG_DECAY_LEN   = 3'd1;
    localparam logic [2:0] CFG_RELEASE_LEN = 3'd2;
    localparam logic [2:0] CFG_END_LEN     = 3'd3;
    localparam logic [2:0] CFG_GLIDE_LEN   = 3'd4;
    localparam logic [2:0] CFG_LEVEL_WORDS = 3'd5;
    localparam logic [2:0] CFG_FLOOR_LEVEL = 3'd6;
    localparam logic [2:0] CFG_CURVE_SHAPE = 3'd7;

    typedef struct packed {
        logic [LENGTH_BITS-1:0] attack_len;
        logic [LENGTH_BITS-1:0] decay_len;
        logic [LENGTH_BITS-1:0] release_len;
        logic [LENGTH_BITS-1:0] end_len;
        logic [LENGTH_BITS-1:0] glide_len;
        logic [LEVEL_BITS-1:0]  attack_peak;
        logic [LEVEL_BITS-1:0]  decay_end;
        logic [LEVEL_BITS-1:0]  sustain_lvl;
        logic [LEVEL_BITS-1:0]  end_peak;
        logic [LEVEL_BITS-1:0]  floor_lvl;
        logic [SHAPE_BITS-1:0]  shape_attack;
        logic [SHAPE_BITS-1:0]  shape_decay;
        logic [SHAPE_BITS-1:0]  shape_sustain;
        logic [SHAPE_BITS-1:0]  shape_release;
        logic [SHAPE_BITS-1:0]  shape_end;
    } t_cfg;

    function automatic logic [LEVEL_BITS-1:0] clamp_level(input logic [LEVEL_BITS-1:0] v);
        return (v > FULL_LEVEL) ? FULL_LEVEL : v;
    endfunction

endpackage

@@ hw/rtl/sadsr_cfg.sv @@
module sadsr_cfg
    import sadsr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output logic        o_cfg_ready,
    output t_cfg        o_cfg
);

    logic [LENGTH_BITS-1:0] r_attack_len, r_decay_len, r_release_len, r_end_len, r_glide_len;
    logic [63:0]            r_level_words;
    logic [15:0]            r_floor_level;
    logic [59:0]            r_curve_shapes;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack_len   <= '0;
            r_decay_len    <= '0;
            r_release_len  <= '0;
            r_end_len      <= '0;
            r_glide_len    <= '0;
            r_level_words  <= '0;
            r_floor_level  <= '0;
            r_curve_shapes <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ATTACK_LEN:  r_attack_len   <= i_cfg_data[LENGTH_BITS-1:0];
                CFG_DECAY_LEN:   r_decay_len    <= i_cfg_data[LENGTH_BITS-1:0];
                CFG_RELEASE_LEN: r_release_len  <= i_cfg_data[LENGTH_BITS-1:0];
                CFG_END_LEN:     r_end_len      <= i_cfg_data[LENGTH_BITS-1:0];
                CFG_GLIDE_LEN:   r_glide_len    <= i_cfg_data[LENGTH_BITS-1:0];
                CFG_LEVEL_WORDS: r_level_words  <= i_cfg_data;
                CFG_FLOOR_LEVEL: r_floor_level  <= i_cfg_data[15:0];
                CFG_CURVE_SHAPE: r_curve_shapes <= i_cfg_data[59:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cfg.attack_len    = r_attack_len;
        o_cfg.decay_len     = r_decay_len;
        o_cfg.release_len   = r_release_len;
        o_cfg.end_len       = r_end_len;
        o_cfg.glide_len     = r_glide_len;
        o_cfg.attack_peak   = clamp_level(r_level_words[15:0]);
        o_cfg.decay_end     = clamp_level(r_level_words[31:16]);
        o_cfg.sustain_lvl   = clamp_level(r_level_words[47:32]);
        o_cfg.end_peak      = clamp_level(r_level_words[63:48]);
        o_cfg.floor_lvl     = clamp_level(r_floor_level);
        o_cfg.shape_attack  = r_curve_shapes[11:0];
        o_cfg.shape_decay   = r_curve_shapes[23:12];
        o_cfg.shape_sustain = r_curve_shapes[35:24];
        o_cfg.shape_release = r_curve_shapes[47:36];
        o_cfg.shape_end     = r_curve_shapes[59:48];
    end

endmodule

@@ hw/rtl/sadsr_mul.sv @@
module sadsr_mul
    import sadsr_pkg::*;
(
    input  logic                  i_clk,
    input  logic [MUL_BITS-1:0]   i_a,
    input  logic [MUL_BITS-1:0]   i_b,
    output logic [2*MUL_BITS-1:0] o_prod
);

    logic [2*MUL_BITS-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

@@ hw/rtl/shaped_adsr_envelope_generator.sv @@
// Six-stage envelope generator (off, attack, decay, sustain, release, end).
// Input channel (i_in_valid/o_in_ready) carries one item: opcode 0 is a sample
// tick, opcode 1 forces entry into i_target_stage (codes 6 and 7 are ignored).
// Every item gives exactly one output beat (o_out_valid/i_out_ready) with the
// level and stage after the item. Configuration writes (i_cfg_valid, index,
// 64-bit data) are taken every cycle and must only occur while the block idles.
// Multiplies and divides run on one registered 32x32 multiplier and a one-bit-per-cycle
// restoring divider, stepped by the sequencer; one item is in flight at a time.
// Work per item: an ignored command or an off tick goes straight to the output;
// a stage entry with a length above one adds the phase-step divide; a tick
// with zero phase or shape runs only the level multiply; a shaped tick runs
// the log squarings, a divide in attack (a multiply elsewhere), the power
// product unless the exponent reaches 17, and then the level multiply.
// After reset the block builds its 16-entry root table on the multiplier
// with o_in_ready low; config writes are still taken then.
// A finished result sits in the output register: the next item is accepted
// while it waits, and the sequencer holds its next result until the beat
// is taken.
module shaped_adsr_envelope_generator
    import sadsr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_opcode,
    input  logic [2:0]  i_target_stage,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_level,
    output logic [2:0]  o_stage,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    localparam logic [3:0] S_INIT_SQ  = 4'd0;
    localparam logic [3:0] S_INIT_CMP = 4'd1;
    localparam logic [3:0] S_IDLE     = 4'd2;
    localparam logic [3:0] S_DIV      = 4'd3;
    localparam logic [3:0] S_WGT      = 4'd4;
    localparam logic [3:0] S_LOG_SQ   = 4'd5;
    localparam logic [3:0] S_LOG_ACC  = 4'd6;
    localparam logic [3:0] S_E_START  = 4'd7;
    localparam logic [3:0] S_E_ACC    = 4'd8;
    localparam logic [3:0] S_E_CHK    = 4'd9;
    localparam logic [3:0] S_POW_MUL  = 4'd10;
    localparam logic [3:0] S_POW_ACC  = 4'd11;
    localparam logic [3:0] S_LVL_MUL  = 4'd12;
    localparam logic [3:0] S_LVL_ACC  = 4'd13;
    localparam logic [3:0] S_DONE     = 4'd14;

    t_cfg cfg;

    sadsr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    logic [MUL_BITS-1:0]   mul_a, mul_b;
    logic [2*MUL_BITS-1:0] mul_prod;

    sadsr_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    // Control and envelope state
    logic [3:0]             r_state, n_state;
    logic [2:0]             r_stage, n_stage;
    logic [LENGTH_BITS-1:0] r_count, n_count;
    logic [LENGTH_BITS-1:0] r_limit, n_limit;
    logic [15:0]            r_level, n_level;
    logic [16:0]            r_phase, n_phase;
    logic [16:0]            r_step, n_step;
    logic [15:0]            r_seg_start, n_seg_start;
    logic [15:0]            r_seg_end, n_seg_end;
    logic                   r_tick, n_tick;
    logic                   r_out_valid, n_out_valid;
    logic [15:0]            r_out_level, n_out_level;
    logic [2:0]             r_out_stage, n_out_stage;
    // Working registers
    logic [30:0]            r_m, n_m;
    logic [15:0]            r_frac, n_frac;
    logic [4:0]             r_p, n_p;
    logic [4:0]             r_cnt, n_cnt;
    logic [11:0]            r_shape, n_shape;
    logic [28:0]            r_e, n_e;
    logic [30:0]            r_r, n_r;
    logic [3:0]             r_idx, n_idx;
    logic [16:0]            r_w, n_w;
    logic [28:0]            r_dvd, n_dvd;
    logic [23:0]            r_dvs, n_dvs;
    logic [23:0]            r_rem, n_rem;
    logic [28:0]            r_quo, n_quo;
    logic                   r_div_e, n_div_e;
    // Root table build
    logic [3:0]             r_k, n_k;
    logic [4:0]             r_bit, n_bit;
    logic [29:0]            r_root, n_root;
    logic [59:0]            r_v, n_v;
    logic [29:0]            r_ctab [16];

    logic                   ctab_we;
    logic [29:0]            init_trial, root_new;
    logic [2:0]             stage_next, ent_s;
    logic [LENGTH_BITS-1:0] e_limit, e_n;
    logic [15:0]            e_level, e_start, e_end;
    logic                   do_enter;
    logic [24:0]            div_trial;
    logic                   div_bit;
    logic [28:0]            quo_fin;
    logic [11:0]            cur_shape;
    logic [4:0]             msb;
    logic [31:0]            sq;
    logic [20:0]            lg;
    logic [30:0]            pow_src;
    logic [16:0]            pow_w;
    logic                   seg_up;
    logic [15:0]            seg_diff, delta;
    logic [17:0]            phase_sum;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_level     = r_out_level;
    assign o_stage     = r_out_stage;

    // Stage entry values
    always_comb begin
        stage_next = (r_stage >= ST_END) ? ST_OFF : r_stage + 3'd1;
        ent_s      = (i_opcode == OP_ENTER) ? i_target_stage : stage_next;
        e_limit    = '0;
        e_level    = r_level;
        e_start    = r_seg_start;
        e_end      = r_seg_end;
        case (ent_s)
            ST_ATTACK: begin
                e_limit = cfg.attack_len;
                e_level = cfg.floor_lvl;
                e_start = cfg.floor_lvl;
                e_end   = cfg.attack_peak;
            end
            ST_DECAY: begin
                e_limit = cfg.decay_len;
                e_level = cfg.attack_peak;
                e_start = cfg.attack_peak;
                e_end   = cfg.decay_end;
            end
            ST_SUSTAIN: begin
                e_level = cfg.decay_end;
                e_start = cfg.decay_end;
                e_end   = cfg.sustain_lvl;
            end
            ST_RELEASE: begin
                e_limit = cfg.release_len;
                e_start = r_level;
                e_end   = cfg.end_peak;
            end
            ST_END: begin
                e_limit = cfg.end_len;
                e_start = cfg.end_peak;
                e_end   = cfg.floor_lvl;
            end
            default: begin
                e_level = '0;
            end
        endcase
        e_n = (ent_s == ST_SUSTAIN) ? cfg.glide_len : e_limit;
    end

    always_comb begin
        case (r_stage)
            ST_ATTACK:  cur_shape = cfg.shape_attack;
            ST_DECAY:   cur_shape = cfg.shape_decay;
            ST_SUSTAIN: cur_shape = cfg.shape_sustain;
            ST_RELEASE: cur_shape = cfg.shape_release;
            ST_END:     cur_shape = cfg.shape_end;
            default:    cur_shape = '0;
        endcase
        msb = '0;
        for (int i = 0; i < 17; i++) begin
            if (r_phase[i]) begin
                msb = 5'(i);
            end
        end
    end

    always_comb begin
        n_state = r_state;     n_stage = r_stage;     n_count = r_count;
        n_limit = r_limit;     n_level = r_level;     n_phase = r_phase;
        n_step = r_step;       n_seg_start = r_seg_start;
        n_seg_end = r_seg_end; n_tick = r_tick;
        n_out_valid = r_out_valid; n_out_level = r_out_level;
        n_out_stage = r_out_stage;
        n_m = r_m;   n_frac = r_frac;   n_p = r_p;     n_cnt = r_cnt;
        n_shape = r_shape; n_e = r_e;   n_r = r_r;     n_idx = r_idx;
        n_w = r_w;   n_dvd = r_dvd;     n_dvs = r_dvs; n_rem = r_rem;
        n_quo = r_quo; n_div_e = r_div_e;
        n_k = r_k;   n_bit = r_bit;     n_root = r_root; n_v = r_v;
        mul_a = '0;
        mul_b = '0;
        ctab_we = 1'b0;
        do_enter = 1'b0;

        init_trial = r_root | (30'd1 << r_bit);
        root_new   = (mul_prod <= {4'd0, r_v}) ? init_trial : r_root;
        div_trial  = {r_rem, r_dvd[28]};
        div_bit    = (div_trial >= {1'b0, r_dvs});
        quo_fin    = {r_quo[27:0], div_bit};
        sq         = mul_prod[61:30];
        lg         = {5'd16 - r_p, 16'd0} - {5'd0, r_frac};
        pow_src    = (r_state == S_POW_ACC) ? mul_prod[60:30] : r_r;
        pow_w      = 17'(pow_src >> (5'd14 + r_e[20:16]));
        seg_up     = (r_seg_end >= r_seg_start);
        seg_diff   = seg_up ? (r_seg_end - r_seg_start) : (r_seg_start - r_seg_end);
        delta      = mul_prod[31:16];
        phase_sum  = {1'b0, r_phase} + {1'b0, r_step};

        // drop the output beat once taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_INIT_SQ: begin
                mul_a   = 32'(init_trial);
                mul_b   = 32'(init_trial);
                n_state = S_INIT_CMP;
            end
            S_INIT_CMP: begin
                if (r_bit == 5'd0) begin
                    ctab_we = 1'b1;
                    n_v     = {root_new, 30'd0};
                    n_root  = '0;
                    n_bit   = 5'd29;
                    n_k     = r_k + 4'd1;
                    n_state = (r_k == 4'd15) ? S_IDLE : S_INIT_SQ;
                end else begin
                    n_root  = root_new;
                    n_bit   = r_bit - 5'd1;
                    n_state = S_INIT_SQ;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_opcode == OP_ENTER) begin
                        do_enter = (i_target_stage <= ST_END);
                        n_tick   = 1'b0;
                        n_state  = S_DONE;
                    end else if (r_stage == ST_OFF) begin
                        n_state = S_DONE;
                    end else begin
                        n_tick   = 1'b1;
                        n_state  = S_WGT;
                        do_enter = (r_stage != ST_SUSTAIN) && (r_count == r_limit);
                    end
                    if (do_enter) begin
                        n_stage     = ent_s;
                        n_count     = '0;
                        n_phase     = '0;
                        n_limit     = e_limit;
                        n_level     = e_level;
                        n_seg_start = e_start;
                        n_seg_end   = e_end;
                        if (e_n > 24'd1) begin
                            n_dvd   = 29'd65536;
                            n_dvs   = e_n - 24'd1;
                            n_rem   = '0;
                            n_quo   = '0;
                            n_cnt   = '0;
                            n_div_e = 1'b0;
                            n_state = S_DIV;
                        end else begin
                            n_step = ONE_Q16;
                        end
                    end
                end
            end
            S_DIV: begin
                n_rem = div_bit ? 24'(div_trial - {1'b0, r_dvs}) : div_trial[23:0];
                n_quo = quo_fin;
                n_dvd = {r_dvd[27:0], 1'b0};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd28) begin
                    if (r_div_e) begin
                        n_e     = quo_fin;
                        n_state = S_E_CHK;
                    end else begin
                        n_step  = quo_fin[16:0];
                        n_state = r_tick ? S_WGT : S_DONE;
                    end
                end
            end
            S_WGT: begin
                if (r_stage == ST_OFF) begin
                    n_state = S_DONE;
                end else if (r_phase == '0 || cur_shape == '0) begin
                    n_w     = '0;
                    n_state = S_LVL_MUL;
                end else begin
                    n_shape = cur_shape;
                    n_p     = msb;
                    n_m     = 31'(r_phase) << (5'd30 - msb);
                    n_frac  = '0;
                    n_cnt   = '0;
                    n_state = S_LOG_SQ;
                end
            end
            S_LOG_SQ: begin
                mul_a   = {1'b0, r_m};
                mul_b   = {1'b0, r_m};
                n_state = S_LOG_ACC;
            end
            S_LOG_ACC: begin
                if (sq[31]) begin
                    n_m    = sq[31:1];
                    n_frac = {r_frac[14:0], 1'b1};
                end else begin
                    n_m    = sq[30:0];
                    n_frac = {r_frac[14:0], 1'b0};
                end
                n_cnt   = r_cnt + 5'd1;
                n_state = (r_cnt == 5'd15) ? S_E_START : S_LOG_SQ;
            end
            S_E_START: begin
                if (r_stage == ST_ATTACK) begin
                    // attack uses the inverse exponent
                    n_dvd   = {lg, 8'd0};
                    n_dvs   = 24'(r_shape);
                    n_rem   = '0;
                    n_quo   = '0;
                    n_cnt   = '0;
                    n_div_e = 1'b1;
                    n_state = S_DIV;
                end else begin
                    mul_a   = 32'(lg);
                    mul_b   = 32'(r_shape);
                    n_state = S_E_ACC;
                end
            end
            S_E_ACC: begin
                n_e     = 29'(mul_prod[32:8]);
                n_state = S_E_CHK;
            end
            S_E_CHK: begin
                if (r_e[28:16] >= 13'd17) begin
                    n_w     = '0;
                    n_state = S_LVL_MUL;
                end else begin
                    n_r     = 31'h4000_0000;
                    n_idx   = '0;
                    n_state = S_POW_MUL;
                end
            end
            S_POW_MUL: begin
                if (r_e[4'd15 - r_idx]) begin
                    mul_a   = {1'b0, r_r};
                    mul_b   = {2'b0, r_ctab[r_idx]};
                    n_state = S_POW_ACC;
                end else if (r_idx == 4'd15) begin
                    n_w     = pow_w;
                    n_state = S_LVL_MUL;
                end else begin
                    n_idx = r_idx + 4'd1;
                end
            end
            S_POW_ACC: begin
                n_r = pow_src;
                if (r_idx == 4'd15) begin
                    n_w     = pow_w;
                    n_state = S_LVL_MUL;
                end else begin
                    n_idx   = r_idx + 4'd1;
                    n_state = S_POW_MUL;
                end
            end
            S_LVL_MUL: begin
                mul_a   = 32'(seg_diff);
                mul_b   = 32'(r_w);
                n_state = S_LVL_ACC;
            end
            S_LVL_ACC: begin
                n_level = seg_up ? (r_seg_start + delta) : (r_seg_start - delta);
                n_phase = (phase_sum > 18'(ONE_Q16)) ? ONE_Q16 : phase_sum[16:0];
                if (r_stage != ST_SUSTAIN) begin
                    n_count = r_count + 24'd1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_level = r_level;
                    n_out_stage = r_stage;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT_SQ;
            r_stage     <= ST_OFF;
            r_count     <= '0;
            r_limit     <= '0;
            r_level     <= '0;
            r_phase     <= '0;
            r_step      <= '0;
            r_seg_start <= '0;
            r_seg_end   <= '0;
            r_tick      <= 1'b0;
            r_out_valid <= 1'b0;
            r_k         <= '0;
            r_bit       <= 5'd29;
            r_root      <= '0;
            r_v         <= 60'd1 << 59;
        end else begin
            r_state     <= n_state;
            r_stage     <= n_stage;
            r_count     <= n_count;
            r_limit     <= n_limit;
            r_level     <= n_level;
            r_phase     <= n_phase;
            r_step      <= n_step;
            r_seg_start <= n_seg_start;
            r_seg_end   <= n_seg_end;
            r_tick      <= n_tick;
            r_out_valid <= n_out_valid;
            r_k         <= n_k;
            r_bit       <= n_bit;
            r_root      <= n_root;
            r_v         <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_level <= n_out_level;
        r_out_stage <= n_out_stage;
        r_m         <= n_m;
        r_frac      <= n_frac;
        r_p         <= n_p;
        r_cnt       <= n_cnt;
        r_shape     <= n_shape;
        r_e         <= n_e;
        r_r         <= n_r;
        r_idx       <= n_idx;
        r_w         <= n_w;
        r_dvd       <= n_dvd;
        r_dvs       <= n_dvs;
        r_rem       <= n_rem;
        r_quo       <= n_quo;
        r_div_e     <= n_div_e;
        if (ctab_we) begin
            r_ctab[r_k] <= root_new;
        end
    end

`ifndef SYNTHESIS
    a_stage_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stage <= ST_END)
        else $error("stage code out of range");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= FULL_LEVEL)
        else $error("level above full scale");

    a_phase_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= ONE_Q16)
        else $error("phase above one");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("accepted a second item while busy");
`endif

endmodule
